>>> hw/rtl/segment_table_index_translate_assert.svh
// assertion macros used by the checker file
`ifndef SEGMENT_TABLE_INDEX_TRANSLATE_ASSERT_SVH
`define SEGMENT_TABLE_INDEX_TRANSLATE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define STA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define STA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sta_pkg.sv
package sta_pkg;

  localparam logic KIND_ATTACH = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] MODE_LONG  = 2'd1;
  localparam logic [1:0] MODE_SHORT = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_SRC_FULL  = 2'd2;
  localparam logic [1:0] ST_DESC_FULL = 2'd3;

  localparam logic [40:0] SAT32_LIMIT = 41'h0_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] source_handle;
    logic [31:0] first_seq;
    logic [31:0] seq_count;
    logic [31:0] source_total;
    logic [31:0] source_long;
    logic [31:0] source_short;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [39:0] global_index;
    logic [1:0]  count_mode;
  } sta_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_source;
    logic [39:0] local_index;
    logic [5:0]  entry_index;
    logic [39:0] prefix_count;
    logic        merged;
  } sta_out_t;

  typedef struct packed {
    logic [39:0] a;
    logic [39:0] b;
  } sta_alu_req_t;

endpackage

>>> hw/rtl/segment_table_index_translate.sv
// Range descriptor table with global index translation. An attach item scans
// the source table one entry per cycle and then merges into the last
// descriptor, appends a new one or reports a full table. A lookup item
// walks the descriptor memory one descriptor per cycle, one shared adder
// building the running count sum, then on a hit forms the local index in
// S_L_LOC1 and S_L_LOC2. busy is high from acceptance until the result
// strobe, and done_o marks each result for a single cycle with no way for
// the receiver to stall it, so capture it there. fallback_first may be
// written at any time the block is idle; cfg_ready_o is always high.
module segment_table_index_translate
  import sta_pkg::*;
#(
  parameter int MAX_SOURCES     = 16,
  parameter int MAX_DESCRIPTORS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sta_in_t  item_i,
  output logic     done_o,
  output sta_out_t result_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_wdata_i
);

  localparam int SW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int DW  = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int SUW = $clog2(MAX_SOURCES + 1);
  localparam int DUW = $clog2(MAX_DESCRIPTORS + 1);
  localparam int RW  = (SUW > DUW) ? SUW : DUW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_SCAN = 4'd1;
  localparam logic [3:0] S_A_CHK  = 4'd2;
  localparam logic [3:0] S_A_LAST = 4'd3;
  localparam logic [3:0] S_A_APP  = 4'd4;
  localparam logic [3:0] S_A_M1   = 4'd5;
  localparam logic [3:0] S_A_M2   = 4'd6;
  localparam logic [3:0] S_A_M3   = 4'd7;
  localparam logic [3:0] S_L_WALK = 4'd8;
  localparam logic [3:0] S_L_LOC1 = 4'd9;
  localparam logic [3:0] S_L_LOC2 = 4'd10;
  localparam logic [3:0] S_L_FB   = 4'd11;

  typedef struct packed {
    logic [SW-1:0] slot;
    logic [31:0]   first_seq;
    logic [31:0]   cnt_all;
    logic [31:0]   cnt_long;
    logic [31:0]   cnt_short;
    logic [31:0]   range_start;
    logic [31:0]   range_end;
  } desc_t;

  logic [3:0]     state_q, state_d;
  logic           fb_q, fb_d;
  logic [SUW-1:0] src_used_q, src_used_d;
  logic [DUW-1:0] desc_used_q, desc_used_d;
  sta_in_t        in_q, in_d;
  logic [31:0]    cnt_q, cnt_d;
  logic [RW-1:0]  ra_q, ra_d;
  logic           cmp_vld_q, cmp_vld_d;
  logic [RW-1:0]  cmp_idx_q, cmp_idx_d;
  logic           found_q, found_d;
  logic [SW-1:0]  slot_q, slot_d;
  desc_t          desc_q, desc_d;
  logic [39:0]    sum_q, sum_d;
  logic [39:0]    tmp_q, tmp_d;
  sta_out_t       res_q, res_d;
  logic           done_q, done_d;

  logic          src_we;
  logic [SW-1:0] src_waddr, src_raddr;
  logic [15:0]   src_wdata, src_rdata;
  logic          desc_we;
  logic [DW-1:0] desc_waddr, desc_raddr;
  desc_t         desc_wdata, desc_rd;

  sta_alu_req_t  alu_req;
  logic [40:0]   alu_sum;
  logic [31:0]   alu_sat;

  logic          issue;
  logic          match;
  logic          hit;
  logic          join_ok;
  logic [31:0]   walk_cnt;

  sta_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SOURCES)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  sta_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (MAX_DESCRIPTORS)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (desc_waddr),
    .wdata_i (desc_wdata),
    .raddr_i (desc_raddr),
    .rdata_o (desc_rd)
  );

  sta_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum),
    .sat_o (alu_sat)
  );

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign result_o    = res_q;
  assign cfg_ready_o = 1'b1;
  assign fb_d        = (cfg_valid_i && cfg_ready_o) ? cfg_wdata_i : fb_q;

  always_comb begin
    state_d     = state_q;
    src_used_d  = src_used_q;
    desc_used_d = desc_used_q;
    in_d        = in_q;
    cnt_d       = cnt_q;
    ra_d        = ra_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    desc_d      = desc_q;
    sum_d       = sum_q;
    tmp_d       = tmp_q;
    res_d       = res_q;
    done_d      = 1'b0;

    src_we     = 1'b0;
    src_waddr  = slot_q;
    src_wdata  = in_q.source_handle;
    src_raddr  = '0;
    desc_we    = 1'b0;
    desc_waddr = DW'(desc_used_q);
    desc_wdata = desc_q;
    desc_raddr = '0;
    alu_req.a  = '0;
    alu_req.b  = '0;

    issue   = 1'b0;
    match   = 1'b0;
    hit     = 1'b0;
    join_ok = 1'b0;

    if (in_q.count_mode == MODE_LONG) begin
      walk_cnt = desc_rd.cnt_long;
    end else if (in_q.count_mode == MODE_SHORT) begin
      walk_cnt = desc_rd.cnt_short;
    end else begin
      walk_cnt = desc_rd.cnt_all;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          in_d = item_i;
          // zero or oversized request means the whole source
          if (item_i.seq_count == 32'd0 || item_i.seq_count > item_i.source_total) begin
            cnt_d = item_i.source_total;
          end else begin
            cnt_d = item_i.seq_count;
          end
          ra_d      = '0;
          cmp_vld_d = 1'b0;
          found_d   = 1'b0;
          sum_d     = '0;
          state_d   = (item_i.kind == KIND_LOOKUP) ? S_L_WALK : S_A_SCAN;
        end
      end

      S_A_SCAN: begin
        src_raddr = ra_q[SW-1:0];
        issue     = (ra_q < RW'(src_used_q));
        match     = cmp_vld_q && (src_rdata == in_q.source_handle);
        if (issue) begin
          ra_d = ra_q + RW'(1);
        end
        cmp_vld_d = issue;
        cmp_idx_d = ra_q;
        if (match) begin
          found_d   = 1'b1;
          slot_d    = cmp_idx_q[SW-1:0];
          cmp_vld_d = 1'b0;
          state_d   = S_A_CHK;
        end else if (!cmp_vld_q && !issue) begin
          slot_d  = SW'(src_used_q);
          state_d = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (!found_q && src_used_q == SUW'(MAX_SOURCES)) begin
          res_d   = '0;
          res_d.status = ST_SRC_FULL;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (found_q && desc_used_q != '0) begin
          desc_raddr = DW'(desc_used_q - DUW'(1));
          state_d    = S_A_LAST;
        end else begin
          state_d = S_A_APP;
        end
      end

      S_A_LAST: begin
        alu_req.a = 40'(desc_rd.first_seq);
        alu_req.b = 40'(desc_rd.cnt_all);
        join_ok   = (desc_rd.slot == slot_q) &&
                    (alu_sum == 41'(in_q.first_seq)) &&
                    (desc_rd.range_start == in_q.range_start) &&
                    (desc_rd.range_end == in_q.range_end);
        desc_d  = desc_rd;
        state_d = join_ok ? S_A_M1 : S_A_APP;
      end

      S_A_APP: begin
        res_d  = '0;
        done_d = 1'b1;
        state_d = S_IDLE;
        if (desc_used_q == DUW'(MAX_DESCRIPTORS)) begin
          res_d.status = ST_DESC_FULL;
        end else begin
          if (!found_q) begin
            src_we     = 1'b1;
            src_used_d = src_used_q + SUW'(1);
          end
          desc_we                = 1'b1;
          desc_wdata.slot        = slot_q;
          desc_wdata.first_seq   = in_q.first_seq;
          desc_wdata.cnt_all     = cnt_q;
          desc_wdata.cnt_long    = in_q.source_long;
          desc_wdata.cnt_short   = in_q.source_short;
          desc_wdata.range_start = in_q.range_start;
          desc_wdata.range_end   = in_q.range_end;
          desc_used_d            = desc_used_q + DUW'(1);
          res_d.status           = ST_OK;
          res_d.entry_index      = 6'(desc_used_q);
        end
      end

      S_A_M1: begin
        alu_req.a      = 40'(desc_q.cnt_all);
        alu_req.b      = 40'(cnt_q);
        desc_d.cnt_all = alu_sat;
        state_d        = S_A_M2;
      end

      S_A_M2: begin
        alu_req.a       = 40'(desc_q.cnt_long);
        alu_req.b       = 40'(in_q.source_long);
        desc_d.cnt_long = alu_sat;
        state_d         = S_A_M3;
      end

      S_A_M3: begin
        alu_req.a            = 40'(desc_q.cnt_short);
        alu_req.b            = 40'(in_q.source_short);
        desc_we              = 1'b1;
        desc_waddr           = DW'(desc_used_q - DUW'(1));
        desc_wdata           = desc_q;
        desc_wdata.cnt_short = alu_sat;
        res_d                = '0;
        res_d.status         = ST_OK;
        res_d.entry_index    = 6'(desc_used_q - DUW'(1));
        res_d.merged         = 1'b1;
        done_d               = 1'b1;
        state_d              = S_IDLE;
      end

      S_L_WALK: begin
        // read address runs one ahead of the compare
        desc_raddr = ra_q[DW-1:0];
        src_raddr  = '0;
        issue      = (ra_q < RW'(desc_used_q));
        alu_req.a  = sum_q;
        alu_req.b  = 40'(walk_cnt);
        hit        = cmp_vld_q && (41'(in_q.global_index) < alu_sum);
        if (hit) begin
          desc_d    = desc_rd;
          cmp_vld_d = 1'b0;
          state_d   = S_L_LOC1;
        end else begin
          if (cmp_vld_q) begin
            sum_d = alu_sum[39:0];
          end
          if (issue) begin
            ra_d = ra_q + RW'(1);
          end
          cmp_vld_d = issue;
          cmp_idx_d = ra_q;
          if (!cmp_vld_q && !issue) begin
            if (fb_q && src_used_q != '0) begin
              state_d = S_L_FB;
            end else begin
              res_d              = '0;
              res_d.status       = ST_NOT_FOUND;
              res_d.prefix_count = sum_q;
              done_d             = 1'b1;
              state_d            = S_IDLE;
            end
          end
        end
      end

      S_L_LOC1: begin
        // first - sum - 1, modulo 2^40
        alu_req.a = 40'(desc_q.first_seq);
        alu_req.b = ~sum_q;
        tmp_d     = alu_sum[39:0];
        src_raddr = desc_q.slot;
        state_d   = S_L_LOC2;
      end

      S_L_LOC2: begin
        alu_req.a          = in_q.global_index;
        alu_req.b          = tmp_q;
        res_d.status       = ST_OK;
        res_d.found_source = src_rdata;
        res_d.local_index  = alu_sum[39:0];
        res_d.entry_index  = 6'(cmp_idx_q);
        res_d.prefix_count = sum_q;
        res_d.merged       = 1'b0;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end

      S_L_FB: begin
        res_d.status       = ST_OK;
        res_d.found_source = src_rdata;
        res_d.local_index  = in_q.global_index;
        res_d.entry_index  = '0;
        res_d.prefix_count = sum_q;
        res_d.merged       = 1'b0;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fb_q        <= 1'b0;
      src_used_q  <= '0;
      desc_used_q <= '0;
      cmp_vld_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fb_q        <= fb_d;
      src_used_q  <= src_used_d;
      desc_used_q <= desc_used_d;
      cmp_vld_q   <= cmp_vld_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    cnt_q     <= cnt_d;
    ra_q      <= ra_d;
    cmp_idx_q <= cmp_idx_d;
    found_q   <= found_d;
    slot_q    <= slot_d;
    desc_q    <= desc_d;
    sum_q     <= sum_d;
    tmp_q     <= tmp_d;
    res_q     <= res_d;
  end

endmodule

>>> hw/rtl/sta_ram.sv
module sta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/sta_alu.sv
module sta_alu
  import sta_pkg::*;
(
  input  sta_alu_req_t req_i,
  output logic [40:0]  sum_o,
  output logic [31:0]  sat_o
);

  assign sum_o = {1'b0, req_i.a} + {1'b0, req_i.b};
  // saturating form used when merging counts
  assign sat_o = (sum_o > SAT32_LIMIT) ? 32'hFFFF_FFFF : sum_o[31:0];

endmodule

>>> hw/rtl/sta_checker.sv
`include "segment_table_index_translate_assert.svh"

module sta_checker
  import sta_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_i,
  input sta_out_t result_i
);

  // an accepted item makes the block busy in the next cycle
  `STA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted item not busy")
  // one item gives one result, never two strobes in a row
  `STA_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_i, !done_i, "result strobe repeated")
  // the result is shown once the block is free again
  `STA_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_i, !busy, "result while busy")
  // error results carry no source and no merge
  `STA_ASSERT_NOW(a_err_clean, clk_i, rst_ni, done_i && result_i.status != ST_OK,
                  result_i.found_source == 16'h0 && !result_i.merged, "dirty error result")

endmodule

bind segment_table_index_translate sta_checker u_sta_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_i   (done_o),
  .result_i (result_o)
);

>>> test/tb.sv
`timescale 1ns / 1ps

import sta_pkg::*;

class range_table_scoreboard;
  localparam int SOURCE_SLOTS = 16;
  localparam int DESC_SLOTS   = 64;

  typedef struct {
    int          slot;
    logic [31:0] first;
    logic [31:0] all_cnt;
    logic [31:0] long_cnt;
    logic [31:0] short_cnt;
    logic [31:0] lo_bound;
    logic [31:0] hi_bound;
  } range_desc_t;

  bit          fallback;
  logic [15:0] handles[SOURCE_SLOTS];
  int          n_src;
  range_desc_t descs[DESC_SLOTS];
  int          n_desc;
  sta_out_t    expected_q[$];
  int          errors;

  function logic [31:0] count_in_mode(int i, logic [1:0] mode);
    case (mode)
      MODE_LONG:  return descs[i].long_cnt;
      MODE_SHORT: return descs[i].short_cnt;
      default:    return descs[i].all_cnt;
    endcase
  endfunction

  function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [40:0] s;
    s = {9'd0, a} + {9'd0, b};
    return (s > SAT32_LIMIT) ? SAT32_LIMIT[31:0] : s[31:0];
  endfunction

  function void note_item(sta_in_t it);
    sta_out_t    res;
    logic [31:0] cnt;
    logic [63:0] sum;
    logic [63:0] c;
    int          slot;
    bit          known;
    bit          hit;
    int          last;
    res = '0;
    if (it.kind == KIND_LOOKUP) begin
      sum = 0;
      hit = 0;
      for (int i = 0; i < n_desc && !hit; i++) begin
        c = 64'(count_in_mode(i, it.count_mode));
        if (64'(it.global_index) < sum + c) begin
          res.found_source = handles[descs[i].slot];
          res.local_index  = 40'(64'(it.global_index) - sum + 64'(descs[i].first) - 64'd1);
          res.entry_index  = 6'(i);
          res.prefix_count = sum[39:0];
          hit = 1;
        end else begin
          sum += c;
        end
      end
      if (!hit) begin
        res.prefix_count = sum[39:0];
        if (fallback && n_src > 0) begin
          res.found_source = handles[0];
          res.local_index  = it.global_index;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
    end else begin
      cnt = it.seq_count;
      if (cnt == 0 || cnt > it.source_total) cnt = it.source_total;
      known = 0;
      slot  = 0;
      for (int i = 0; i < n_src; i++) begin
        if (handles[i] == it.source_handle) begin
          slot  = i;
          known = 1;
        end
      end
      last = n_desc - 1;
      if (!known && n_src >= SOURCE_SLOTS) begin
        res.status = ST_SRC_FULL;
      end else begin
        if (!known) slot = n_src;
        // join only a known source that carries straight on with the same bounds
        if (known && n_desc > 0 && descs[last].slot == slot &&
            {1'b0, descs[last].first} + {1'b0, descs[last].all_cnt} ==
            {1'b0, it.first_seq} &&
            descs[last].lo_bound == it.range_start &&
            descs[last].hi_bound == it.range_end) begin
          descs[last].all_cnt   = sat_add(descs[last].all_cnt, cnt);
          descs[last].long_cnt  = sat_add(descs[last].long_cnt, it.source_long);
          descs[last].short_cnt = sat_add(descs[last].short_cnt, it.source_short);
          res.entry_index = 6'(last);
          res.merged      = 1'b1;
        end else if (n_desc >= DESC_SLOTS) begin
          res.status = ST_DESC_FULL;
        end else begin
          if (!known) begin
            handles[n_src] = it.source_handle;
            n_src++;
          end
          descs[n_desc] = '{slot, it.first_seq, cnt, it.source_long, it.source_short,
                            it.range_start, it.range_end};
          res.entry_index = 6'(n_desc);
          n_desc++;
        end
      end
    end
    expected_q.push_back(res);
  endfunction

  function void compare_field(string name, logic [39:0] want, logic [39:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(sta_out_t act);
    sta_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result with no item outstanding, expected none, actual %p", $time, act);
      return;
    end
    want = expected_q.pop_front();
    compare_field("status", 40'(want.status), 40'(act.status));
    compare_field("found_source", 40'(want.found_source), 40'(act.found_source));
    compare_field("local_index", want.local_index, act.local_index);
    compare_field("entry_index", 40'(want.entry_index), 40'(act.entry_index));
    compare_field("prefix_count", want.prefix_count, act.prefix_count);
    compare_field("merged", 40'(want.merged), 40'(act.merged));
  endfunction
endclass

module tb;
  localparam logic [1:0] MODE_ALL   = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  sta_in_t  item_i;
  logic     done_o;
  sta_out_t result_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic     cfg_wdata_i;

  range_table_scoreboard sb;

  segment_table_index_translate i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  task automatic idle(int cycles);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(sta_in_t it);
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic write_fallback(logic value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.fallback = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic sta_in_t attach_item(logic [15:0] handle, logic [31:0] first,
                                          logic [31:0] cnt, logic [31:0] total,
                                          logic [31:0] lng, logic [31:0] shr,
                                          logic [31:0] lo, logic [31:0] hi);
    sta_in_t it;
    it = '0;
    it.kind          = KIND_ATTACH;
    it.source_handle = handle;
    it.first_seq     = first;
    it.seq_count     = cnt;
    it.source_total  = total;
    it.source_long   = lng;
    it.source_short  = shr;
    it.range_start   = lo;
    it.range_end     = hi;
    return it;
  endfunction

  function automatic sta_in_t lookup_item(logic [39:0] idx, logic [1:0] mode);
    sta_in_t it;
    it = '0;
    it.kind         = KIND_LOOKUP;
    it.global_index = idx;
    it.count_mode   = mode;
    return it;
  endfunction

  function automatic sta_in_t random_item();
    sta_in_t     it;
    int          pick;
    int          last;
    logic [63:0] span;
    it.kind          = 1'($urandom);
    it.source_handle = 16'($urandom);
    it.first_seq     = $urandom;
    it.seq_count     = $urandom;
    it.source_total  = $urandom;
    it.source_long   = $urandom;
    it.source_short  = $urandom;
    it.range_start   = $urandom;
    it.range_end     = $urandom;
    it.global_index  = 40'({$urandom, $urandom});
    it.count_mode    = 2'($urandom);
    if ($urandom_range(0, 9) < 4) begin
      it.kind = KIND_ATTACH;
      // mostly modest counts so that lookups land inside the table
      if ($urandom_range(0, 7) != 0) begin
        it.seq_count    = $urandom_range(0, 300);
        it.source_total = $urandom_range(0, 400);
        it.source_long  = $urandom_range(0, 200);
        it.source_short = $urandom_range(0, 200);
      end
      pick = $urandom_range(0, 99);
      if (sb.n_desc > 0 && pick < 45) begin
        last = sb.n_desc - 1;
        it.source_handle = sb.handles[sb.descs[last].slot];
        it.first_seq     = sb.descs[last].first + sb.descs[last].all_cnt;
        it.range_start   = sb.descs[last].lo_bound;
        it.range_end     = sb.descs[last].hi_bound;
      end else if (sb.n_src > 0 && pick < 80) begin
        it.source_handle = sb.handles[$urandom_range(0, sb.n_src - 1)];
        if ($urandom_range(0, 1) != 0) it.first_seq = $urandom_range(0, 1000);
      end
    end else begin
      it.kind = KIND_LOOKUP;
      if ($urandom_range(0, 7) != 0) begin
        span = 64'd8;
        for (int i = 0; i < sb.n_desc; i++) span += 64'(sb.count_in_mode(i, it.count_mode));
        it.global_index = 40'({$urandom, $urandom} % span);
      end
    end
    return it;
  endfunction

  task automatic run_random(int n);
    int burst_left;
    burst_left = 0;
    for (int k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        idle($urandom_range(0, 90));
      end
      burst_left--;
      if ($urandom_range(0, 49) == 0) wait_drained();
      send_item(random_item());
    end
  endtask

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb          = new;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, fallback set but no source yet
    write_fallback(1'b1);
    send_item(lookup_item('1, MODE_ALL));
    send_item(lookup_item('0, MODE_SPARE));

    write_fallback(1'b0);
    // zero count takes the whole source, then a clamped merge
    send_item(attach_item(16'h0000, 32'd1, 32'd0, 32'd100, 32'd60, 32'd40, 32'd0, 32'd0));
    send_item(attach_item(16'h0000, 32'd101, 32'd500, 32'd50, 32'd5, 32'd45, 32'd0, 32'd0));
    // first item zero, full counts, then a merge that saturates
    send_item(attach_item(16'hFFFF, 32'd0, '1, '1, '1, '1, '1, '1));
    send_item(attach_item(16'hFFFF, '1, 32'd7, 32'd9, 32'd3, 32'd3, '1, '1));
    // contiguous but different bounds appends
    send_item(attach_item(16'hFFFF, '1, 32'd3, 32'd3, 32'd2, 32'd1, 32'd1, '1));
    send_item(attach_item(16'h5A5A, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_item(lookup_item(40'd0, MODE_ALL));
    send_item(lookup_item(40'd149, MODE_ALL));
    send_item(lookup_item(40'd150, MODE_ALL));
    send_item(lookup_item(40'd64, MODE_LONG));
    send_item(lookup_item(40'd85, MODE_SHORT));
    send_item(lookup_item(40'd200, MODE_SPARE));
    send_item(lookup_item('1, MODE_SPARE));

    write_fallback(1'b1);
    send_item(lookup_item('1, MODE_LONG));
    send_item(lookup_item(40'd10, MODE_ALL));

    for (int ph = 0; ph < 4; ph++) begin
      write_fallback(1'($urandom));
      run_random(95);
    end

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
